[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/kpu_pkg.sv]
// Package: widths, register codes and helpers of the k-permutation unranker.
package kpu_pkg;

	localparam int RANK_W    = 45;
	localparam int FIELD_W   = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int MAX_N_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ARR_LEN  = 1'b1;

	localparam logic [CFG_W-1:0] SET_SIZE_RST = 5'd16;
	localparam logic [CFG_W-1:0] ARR_LEN_RST  = 5'd16;

	// Upper bound on the bits of n!, hence of any P(m,j) with j <= m <= n.
	function automatic int fall_bits(int n);
		int acc;
		acc = 0;
		for (int i = 1; i <= n; i++) begin
			acc += $clog2(i + 1);
		end
		return acc;
	endfunction

endpackage

[sv/kpu_req_if.sv]
// Request channel: one rank per request.
interface kpu_req_if;
	import kpu_pkg::*;

	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;

	modport source (output valid, output rank, input ready);
	modport sink   (input valid, input rank, output ready);
endinterface

[sv/kpu_res_if.sv]
// Result channel: one arrangement element per transfer.
interface kpu_res_if;
	import kpu_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] element;
	logic [FIELD_W-1:0] position;
	logic               last;
	logic               error;

	modport source (output valid, output element, output position, output last,
		output error, input ready);
	modport sink   (input valid, input element, input position, input last,
		input error, output ready);
endinterface

[sv/k_permutation_unrank.sv]
// Lexicographic k-permutation unranker. A request carries a rank; with n (set_size)
// and k (arrangement_length) it returns k results, the element at each position of
// the rank-th ordered selection of k values from 0..n-1, the final one marked last.
// A zero n or k, n above MAX_N, k above n, or a rank of at least P(n,k) gives one
// result with error set. One request is worked at a time: a shared 5-bit-factor
// multiplier builds P(n,k) for the range check and then each P(m-1,j-1), and a
// shift-subtract unit takes $clog2(MAX_N) steps per quotient. A bad n or k goes
// from IDLE straight to EMIT; a rank out of range is flagged once RANGE has built
// P(n,k). Each result waits in EMIT until the output register is free, so the
// result side can stall the work. The next request is taken while the final result
// still waits in the output register.
module k_permutation_unrank #(
	parameter int MAX_N = kpu_pkg::MAX_N_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kpu_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [kpu_pkg::CFG_W-1:0]     cfg_data,
	kpu_req_if.sink                       req,
	kpu_res_if.source                     res
);
	import kpu_pkg::*;

	localparam int QW  = $clog2(MAX_N);
	localparam int MW  = $clog2(MAX_N + 1);
	localparam int FW  = fall_bits(MAX_N);
	localparam int DVW = FW + QW - 1;
	localparam int CW  = (RANK_W > DVW) ? RANK_W : DVW;

	typedef enum logic [2:0] {ST_IDLE, ST_RANGE, ST_FPROD, ST_DIV, ST_EMIT} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   set_size_q;
	logic [CFG_W-1:0]   arr_len_q;
	logic [RANK_W-1:0]  r_q;
	logic [FW-1:0]      prod_q;
	logic [MW-1:0]      fac_q;
	logic [MW-1:0]      steps_q;
	logic [DVW-1:0]     dv_q;
	logic [QW-1:0]      d_q;
	logic [MW-1:0]      m_q;
	logic [MW-1:0]      j_q;
	logic [QW-1:0]      pos_q;
	logic               err_q;
	logic [QW-1:0]      avail_q [MAX_N];

	logic               out_v_q;
	logic [FIELD_W-1:0] out_elem_q;
	logic [FIELD_W-1:0] out_pos_q;
	logic               out_last_q;
	logic               out_err_q;

	logic               bad_cfg;
	logic [FW+MW-1:0]   mul_res;
	logic [CW-1:0]      r_ext;
	logic [CW-1:0]      dv_ext;
	logic [CW-1:0]      diff;
	logic               ge_dv;
	logic               ge_prod;
	logic [QW-1:0]      dsel;
	logic               slot_free;

	assign bad_cfg = (set_size_q == '0) || (arr_len_q == '0)
		|| (set_size_q > CFG_W'(MAX_N)) || (arr_len_q > set_size_q);
	assign mul_res   = prod_q * fac_q;
	assign r_ext     = CW'(r_q);
	assign dv_ext    = CW'(dv_q);
	assign diff      = r_ext - dv_ext;
	assign ge_dv     = r_ext >= dv_ext;
	assign ge_prod   = r_ext >= CW'(prod_q);
	assign dsel      = ({1'b0, d_q} >= (QW + 1)'(m_q)) ? QW'(m_q - 1'b1) : d_q;
	assign slot_free = !out_v_q || res.ready;

	assign req.ready    = (state_q == ST_IDLE);
	assign res.valid    = out_v_q;
	assign res.element  = out_elem_q;
	assign res.position = out_pos_q;
	assign res.last     = out_last_q;
	assign res.error    = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= SET_SIZE_RST;
			arr_len_q  <= ARR_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SET_SIZE: set_size_q <= cfg_data;
				REG_ARR_LEN:  arr_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			r_q        <= '0;
			prod_q     <= '0;
			fac_q      <= '0;
			steps_q    <= '0;
			dv_q       <= '0;
			d_q        <= '0;
			m_q        <= '0;
			j_q        <= '0;
			pos_q      <= '0;
			err_q      <= 1'b0;
			out_v_q    <= 1'b0;
			out_elem_q <= '0;
			out_pos_q  <= '0;
			out_last_q <= 1'b0;
			out_err_q  <= 1'b0;
			for (int i = 0; i < MAX_N; i++) begin
				avail_q[i] <= '0;
			end
		end else begin
			if (res.ready && state_q != ST_EMIT) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						r_q     <= req.rank;
						m_q     <= MW'(set_size_q);
						j_q     <= MW'(arr_len_q);
						pos_q   <= '0;
						err_q   <= bad_cfg;
						prod_q  <= FW'(1);
						fac_q   <= MW'(set_size_q);
						steps_q <= MW'(arr_len_q);
						for (int i = 0; i < MAX_N; i++) begin
							avail_q[i] <= QW'(i);
						end
						state_q <= bad_cfg ? ST_EMIT : ST_RANGE;
					end
				end
				ST_RANGE: begin
					if (steps_q != '0) begin
						prod_q  <= mul_res[FW-1:0];
						fac_q   <= fac_q - 1'b1;
						steps_q <= steps_q - 1'b1;
					end else if (ge_prod) begin
						err_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						prod_q  <= FW'(1);
						fac_q   <= m_q - 1'b1;
						steps_q <= j_q - 1'b1;
						state_q <= ST_FPROD;
					end
				end
				ST_FPROD: begin
					if (steps_q != '0) begin
						prod_q  <= mul_res[FW-1:0];
						fac_q   <= fac_q - 1'b1;
						steps_q <= steps_q - 1'b1;
					end else begin
						dv_q    <= DVW'(prod_q) << (QW - 1);
						d_q     <= '0;
						steps_q <= MW'(QW);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (steps_q != '0) begin
						if (ge_dv) begin
							r_q <= diff[RANK_W-1:0];
						end
						d_q     <= QW'({d_q, ge_dv});
						dv_q    <= dv_q >> 1;
						steps_q <= steps_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_v_q <= 1'b1;
						if (err_q) begin
							out_elem_q <= '0;
							out_pos_q  <= '0;
							out_last_q <= 1'b1;
							out_err_q  <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							out_elem_q <= FIELD_W'(avail_q[dsel]);
							out_pos_q  <= FIELD_W'(pos_q);
							out_last_q <= (j_q == MW'(1));
							out_err_q  <= 1'b0;
							for (int i = 0; i < MAX_N - 1; i++) begin
								if (QW'(i) >= dsel) begin
									avail_q[i] <= avail_q[i + 1];
								end
							end
							m_q   <= m_q - 1'b1;
							j_q   <= j_q - 1'b1;
							pos_q <= pos_q + 1'b1;
							if (j_q == MW'(1)) begin
								state_q <= ST_IDLE;
							end else begin
								prod_q  <= FW'(1);
								fac_q   <= m_q - MW'(2);
								steps_q <= j_q - MW'(2);
								state_q <= ST_FPROD;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/kpu_chk.sv]
// Port checker for the k-permutation unranker, bound into every k_permutation_unrank instance.
`include "assert_macros.svh"

module kpu_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [kpu_pkg::FIELD_W-1:0] res_element,
	input logic [kpu_pkg::FIELD_W-1:0] res_position,
	input logic                        res_last,
	input logic                        res_error
);
	import kpu_pkg::*;

	`ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_element) && $stable(res_position) && $stable(res_last) && $stable(res_error))
	`ASSERT_IMP(a_err_single, res_valid && res_error, res_last && res_element == '0 && res_position == '0)
	`ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)
	`ASSERT_IMP(a_busy_mid_item, res_valid && !res_last, !req_ready)

endmodule

bind k_permutation_unrank kpu_chk u_kpu_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_element  (res.element),
	.res_position (res.position),
	.res_last     (res.last),
	.res_error    (res.error)
);
